### sv/msbr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msbr_pkg: shared types and constants of the MSB-first bit reader
// Request codes, sequencer states, beat payloads and the index advance rule.
// ----------------------------------------------------------------------------
package msbr_pkg;

	localparam int BUFFER_BYTES   = 4096;
	localparam int ADDR_W         = $clog2(BUFFER_BYTES);
	localparam int IDX_W          = ADDR_W + 1;
	localparam int MAX_READ_BITS  = 32;
	localparam int MAX_COPY_BYTES = 64;
	localparam int CNT_W          = 7;

	localparam logic [3:0]       BIT_MSB  = 4'd7;
	localparam logic [3:0]       BIT_DONE = 4'hF;
	localparam logic [IDX_W-1:0] END_MAX  = IDX_W'(BUFFER_BYTES);

	typedef enum logic [2:0] {
		REQ_WRITE   = 3'd0,
		REQ_BITS    = 3'd1,
		REQ_BYTE    = 3'd2,
		REQ_WORD    = 3'd3,
		REQ_SKIP    = 3'd4,
		REQ_RESTART = 3'd5,
		REQ_COPY    = 3'd6
	} req_code_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_COPY_ADV,
		ST_BYTE_RD,
		ST_BYTE_DATA,
		ST_LOAD,
		ST_BITS,
		ST_COPY_RD,
		ST_COPY_OUT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [11:0] write_addr;
		logic [7:0]  write_data;
		logic [12:0] count;
	} req_t;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
		logic        in_range;
		logic [12:0] next_index;
		logic        next_valid;
	} rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic             clear;
	} adv_t;

	// advance the index by n, saturate at the end, flag range loss
	function automatic adv_t advance(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] n,
			input logic [IDX_W-1:0] lim);
		adv_t         r;
		logic [IDX_W:0] sum;
		sum = {1'b0, idx} + {1'b0, n};
		r.index = idx;
		if (idx < lim) begin
			r.index = (sum > {1'b0, lim}) ? lim : sum[IDX_W-1:0];
		end
		r.clear = (r.index >= lim);
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/msb_first_bit_reader_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core: MSB-first bitstream reader over a byte buffer
//
// Request beats arrive on in_valid/in_ready (in_data), result beats leave on
// out_valid/out_ready (out_data). cfg_wr_en/cfg_wr_data set the buffer size;
// the user must write it only while no request is in flight; the core does
// not enforce this. One request is worked on at a time; in_ready is high only
// between requests. A write gives no beat. Skip and restart go to the emit
// state and give one beat. Get bits shifts one bit per cycle within a byte,
// with a load step before each byte. Get byte/word aligns, then reads and
// appends each byte. Copy aligns, advances the index, then reads and sends
// each byte, paced by the buffer's single read port with registered data.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset clears the index to 0, bit position to the MSB, sets the in-range
// flag and the buffer size to its maximum; buffer contents are not cleared.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire msbr_pkg::req_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output msbr_pkg::rsp_t       out_data,
	input  wire logic            cfg_wr_en,
	input  wire logic [12:0]     cfg_wr_data
);

	msbr_pkg::state_t                 state_q, state_d;
	msbr_pkg::req_code_t              req_q;
	logic [msbr_pkg::IDX_W-1:0]       idx_q;
	logic [3:0]                       bp_q;
	logic                             rok_q;
	logic [msbr_pkg::IDX_W-1:0]       lim_q;
	logic [msbr_pkg::CNT_W-1:0]       cnt_q;
	logic [31:0]                      acc_q;
	logic [msbr_pkg::IDX_W-1:0]       addr_q;
	logic [7:0]                       rd_q;
	logic                             rd_ok_q;
	logic                             out_valid_q;
	msbr_pkg::rsp_t                   out_q;
	logic [7:0]                       mem [msbr_pkg::BUFFER_BYTES];

	logic                             in_fire;
	logic                             out_free;
	logic                             out_load;
	logic                             out_last;
	logic [31:0]                      out_val;
	logic [7:0]                       fetched;
	logic [msbr_pkg::IDX_W-1:0]       rd_idx;
	logic [msbr_pkg::IDX_W-1:0]       adv_n;
	msbr_pkg::adv_t                   adv;
	logic [msbr_pkg::CNT_W-1:0]       sat_bits;
	logic [msbr_pkg::CNT_W-1:0]       sat_copy;
	logic [msbr_pkg::IDX_W-1:0]       nidx;
	logic                             nval;
	msbr_pkg::req_code_t              in_code;

	assign in_ready  = (state_q == msbr_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_code   = msbr_pkg::req_code_t'(in_data.req_type);
	assign fetched   = rd_ok_q ? rd_q : 8'd0;

	assign sat_bits = (in_data.count > msbr_pkg::IDX_W'(msbr_pkg::MAX_READ_BITS)) ?
		msbr_pkg::CNT_W'(msbr_pkg::MAX_READ_BITS) : in_data.count[msbr_pkg::CNT_W-1:0];
	assign sat_copy = (in_data.count > msbr_pkg::IDX_W'(msbr_pkg::MAX_COPY_BYTES)) ?
		msbr_pkg::CNT_W'(msbr_pkg::MAX_COPY_BYTES) : in_data.count[msbr_pkg::CNT_W-1:0];

	assign rd_idx = (state_q == msbr_pkg::ST_COPY_RD || state_q == msbr_pkg::ST_COPY_OUT) ?
		addr_q : idx_q;

	always_comb begin
		adv_n = msbr_pkg::IDX_W'(1);
		if (state_q == msbr_pkg::ST_IDLE) begin
			adv_n = in_data.count;
		end else if (state_q == msbr_pkg::ST_COPY_ADV) begin
			adv_n = msbr_pkg::IDX_W'(cnt_q);
		end
		adv = msbr_pkg::advance(idx_q, adv_n, lim_q);
	end

	always_comb begin
		nidx = idx_q;
		nval = 1'b1;
		if (bp_q != msbr_pkg::BIT_MSB) begin
			if (idx_q < lim_q) begin
				nidx = idx_q + msbr_pkg::IDX_W'(1);
			end else begin
				nval = 1'b0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			msbr_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (in_code)
						msbr_pkg::REQ_BITS:
							state_d = (sat_bits == '0) ? msbr_pkg::ST_EMIT : msbr_pkg::ST_LOAD;
						msbr_pkg::REQ_BYTE, msbr_pkg::REQ_WORD, msbr_pkg::REQ_COPY:
							state_d = msbr_pkg::ST_ALIGN;
						msbr_pkg::REQ_SKIP, msbr_pkg::REQ_RESTART:
							state_d = msbr_pkg::ST_EMIT;
						default: state_d = msbr_pkg::ST_IDLE;
					endcase
				end
			end
			msbr_pkg::ST_ALIGN: begin
				state_d = (req_q == msbr_pkg::REQ_COPY) ? msbr_pkg::ST_COPY_ADV : msbr_pkg::ST_BYTE_RD;
			end
			msbr_pkg::ST_COPY_ADV: begin
				state_d = (cnt_q == '0) ? msbr_pkg::ST_IDLE : msbr_pkg::ST_COPY_RD;
			end
			msbr_pkg::ST_BYTE_RD: state_d = msbr_pkg::ST_BYTE_DATA;
			msbr_pkg::ST_BYTE_DATA: begin
				state_d = (cnt_q == msbr_pkg::CNT_W'(1)) ? msbr_pkg::ST_EMIT : msbr_pkg::ST_BYTE_RD;
			end
			msbr_pkg::ST_LOAD: state_d = msbr_pkg::ST_BITS;
			msbr_pkg::ST_BITS: begin
				if (cnt_q == '0) begin
					state_d = msbr_pkg::ST_EMIT;
				end else if (bp_q == msbr_pkg::BIT_DONE) begin
					state_d = msbr_pkg::ST_LOAD;
				end
			end
			msbr_pkg::ST_COPY_RD: state_d = msbr_pkg::ST_COPY_OUT;
			msbr_pkg::ST_COPY_OUT: begin
				if (out_free) begin
					state_d = (cnt_q == msbr_pkg::CNT_W'(1)) ? msbr_pkg::ST_IDLE : msbr_pkg::ST_COPY_RD;
				end
			end
			msbr_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = msbr_pkg::ST_IDLE;
				end
			end
			default: state_d = msbr_pkg::ST_IDLE;
		endcase
	end

	// result beat control
	always_comb begin
		out_load = 1'b0;
		out_last = 1'b1;
		out_val  = acc_q;
		case (state_q)
			msbr_pkg::ST_EMIT: out_load = out_free;
			msbr_pkg::ST_COPY_OUT: begin
				out_load = out_free;
				out_last = (cnt_q == msbr_pkg::CNT_W'(1));
				out_val  = {24'd0, fetched};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msbr_pkg::ST_IDLE;
			req_q       <= msbr_pkg::REQ_WRITE;
			idx_q       <= '0;
			bp_q        <= msbr_pkg::BIT_MSB;
			rok_q       <= 1'b1;
			lim_q       <= msbr_pkg::END_MAX;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				lim_q <= (cfg_wr_data > msbr_pkg::END_MAX) ? msbr_pkg::END_MAX : cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				msbr_pkg::ST_IDLE: begin
					if (in_fire) begin
						req_q <= in_code;
						case (in_code)
							msbr_pkg::REQ_BITS: cnt_q <= sat_bits;
							msbr_pkg::REQ_BYTE: cnt_q <= msbr_pkg::CNT_W'(1);
							msbr_pkg::REQ_WORD: cnt_q <= msbr_pkg::CNT_W'(2);
							msbr_pkg::REQ_COPY: cnt_q <= sat_copy;
							msbr_pkg::REQ_SKIP: begin
								idx_q <= adv.index;
								if (adv.clear) begin
									rok_q <= 1'b0;
								end
								bp_q <= msbr_pkg::BIT_MSB;
							end
							msbr_pkg::REQ_RESTART: begin
								idx_q <= '0;
								bp_q  <= msbr_pkg::BIT_MSB;
								rok_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				msbr_pkg::ST_ALIGN: begin
					if (bp_q != msbr_pkg::BIT_MSB) begin
						idx_q <= adv.index;
						if (adv.clear) begin
							rok_q <= 1'b0;
						end
						bp_q <= msbr_pkg::BIT_MSB;
					end
				end
				msbr_pkg::ST_COPY_ADV, msbr_pkg::ST_BYTE_DATA: begin
					idx_q <= adv.index;
					if (adv.clear) begin
						rok_q <= 1'b0;
					end
					if (state_q == msbr_pkg::ST_BYTE_DATA) begin
						cnt_q <= cnt_q - msbr_pkg::CNT_W'(1);
					end
				end
				msbr_pkg::ST_BITS: begin
					if (cnt_q != '0) begin
						if (bp_q == msbr_pkg::BIT_DONE) begin
							bp_q  <= msbr_pkg::BIT_MSB;
							idx_q <= adv.index;
							if (adv.clear) begin
								rok_q <= 1'b0;
							end
						end else begin
							bp_q  <= bp_q - 4'd1;
							cnt_q <= cnt_q - msbr_pkg::CNT_W'(1);
						end
					end
				end
				msbr_pkg::ST_COPY_OUT: begin
					if (out_free) begin
						cnt_q <= cnt_q - msbr_pkg::CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && in_code == msbr_pkg::REQ_WRITE) begin
			mem[in_data.write_addr] <= in_data.write_data;
		end
		rd_q <= mem[rd_idx[msbr_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		rd_ok_q <= (rd_idx < lim_q);
		if (in_fire) begin
			acc_q <= '0;
		end
		case (state_q)
			msbr_pkg::ST_COPY_ADV: addr_q <= idx_q;
			msbr_pkg::ST_BYTE_DATA: acc_q <= {acc_q[23:0], fetched};
			msbr_pkg::ST_BITS: begin
				if (cnt_q != '0 && bp_q != msbr_pkg::BIT_DONE) begin
					acc_q <= {acc_q[30:0], fetched[bp_q[2:0]]};
				end
			end
			msbr_pkg::ST_COPY_OUT: begin
				if (out_free) begin
					addr_q <= addr_q + msbr_pkg::IDX_W'(1);
				end
			end
			default: ;
		endcase
		if (out_load) begin
			out_q.value      <= out_val;
			out_q.last       <= out_last;
			out_q.in_range   <= rok_q;
			out_q.next_index <= nidx;
			out_q.next_valid <= nval;
		end
	end

	a_bit_pos_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(bp_q <= msbr_pkg::BIT_MSB) || (bp_q == msbr_pkg::BIT_DONE))
		else $error("bit position out of range");

	a_copy_count_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == msbr_pkg::ST_COPY_OUT || state_q == msbr_pkg::ST_COPY_RD) |-> (cnt_q != '0))
		else $error("copy beat with no bytes left");

	a_beat_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == msbr_pkg::ST_EMIT ||
			state_q == msbr_pkg::ST_COPY_OUT))
		else $error("result beat raised outside an emitting state");

endmodule
`default_nettype wire

### test/msb_first_bit_reader_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader_core_tb: self-checking bench for the MSB-first reader
// Fills the byte buffer and walks a directed table of requests. Then runs
// random request mixes under several buffer sizes and idle patterns. Beats
// are checked against a cycle-free reader model or a fixed table beat.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_core_tb;
	import msbr_pkg::*;

	localparam int CLK_HIGH      = 10;
	localparam int CLK_LOW       = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 54;
	localparam int PHASE_COUNT   = 6;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES   = 50;
	localparam int REPORT_CAP    = 40;
	localparam logic [2:0] REQ_UNUSED = 3'd7;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t beat;
	} plan_row_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_ready;
	req_t        in_data     = '0;
	logic        out_valid;
	logic        out_ready   = 1'b0;
	rsp_t        out_data;
	logic        cfg_wr_en   = 1'b0;
	logic [12:0] cfg_wr_data = '0;

	// reader mirror
	logic [7:0] byte_mirror [BUFFER_BYTES];
	int         index_m  = 0;
	int         bitpos_m = 7;
	logic       range_m  = 1'b1;
	int         size_m   = BUFFER_BYTES;

	rsp_t expected_beats [$];
	rsp_t want_beat;
	int   mismatch_count   = 0;
	int   cycle_count      = 0;
	int   tx_idle_pct      = 0;
	int   rx_idle_pct      = 0;
	bit   hold_off_pending = 1'b0;

	msb_first_bit_reader_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#CLK_LOW;
		clk = 1'b1;
		#CLK_HIGH;
	end

	function automatic int data_limit();
		return (size_m > BUFFER_BYTES) ? BUFFER_BYTES : size_m;
	endfunction

	function automatic logic [7:0] fetch_byte(int a);
		return (a < data_limit()) ? byte_mirror[a] : 8'h00;
	endfunction

	function automatic void step_index(int n);
		int lim;
		lim = data_limit();
		if (index_m < lim) begin
			index_m = index_m + n;
			if (index_m > lim)
				index_m = lim;
		end
		if (index_m >= lim)
			range_m = 1'b0;
	endfunction

	function automatic void align_byte();
		if (bitpos_m != 7) begin
			step_index(1);
			bitpos_m = 7;
		end
	endfunction

	function automatic void queue_result(logic [31:0] v, logic is_last);
		rsp_t b;
		int   nidx;
		logic nval;
		nidx = index_m;
		nval = 1'b1;
		if (bitpos_m != 7) begin
			if (index_m < data_limit())
				nidx = index_m + 1;
			else
				nval = 1'b0;
		end
		b.value      = v;
		b.last       = is_last;
		b.in_range   = range_m;
		b.next_index = nidx[12:0];
		b.next_valid = nval;
		expected_beats.push_back(b);
	endfunction

	function automatic void predict_results(req_t r);
		int          n;
		int          base;
		logic [31:0] acc;
		logic [7:0]  cur;
		logic [7:0]  run [MAX_COPY_BYTES];
		case (r.req_type)
			REQ_WRITE: begin
				byte_mirror[r.write_addr] = r.write_data;
			end
			REQ_BITS: begin
				n = (r.count > MAX_READ_BITS) ? MAX_READ_BITS : int'(r.count);
				acc = '0;
				for (int i = 0; i < n; i++) begin
					if (bitpos_m < 0) begin
						bitpos_m = 7;
						step_index(1);
					end
					cur = fetch_byte(index_m);
					acc = {acc[30:0], cur[bitpos_m]};
					bitpos_m--;
				end
				queue_result(acc, 1'b1);
			end
			REQ_BYTE: begin
				align_byte();
				acc = {24'h0, fetch_byte(index_m)};
				step_index(1);
				queue_result(acc, 1'b1);
			end
			REQ_WORD: begin
				align_byte();
				acc = {16'h0, fetch_byte(index_m), 8'h00};
				step_index(1);
				acc[7:0] = fetch_byte(index_m);
				step_index(1);
				queue_result(acc, 1'b1);
			end
			REQ_SKIP: begin
				step_index(int'(r.count));
				bitpos_m = 7;
				queue_result('0, 1'b1);
			end
			REQ_RESTART: begin
				index_m  = 0;
				bitpos_m = 7;
				range_m  = 1'b1;
				queue_result('0, 1'b1);
			end
			REQ_COPY: begin
				align_byte();
				n = (r.count > MAX_COPY_BYTES) ? MAX_COPY_BYTES : int'(r.count);
				base = index_m;
				for (int i = 0; i < n; i++)
					run[i] = fetch_byte(base + i);
				step_index(n);
				for (int i = 0; i < n; i++)
					queue_result({24'h0, run[i]}, i == n - 1);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic req_t make_req(logic [2:0] code, int addr, int data, int cnt);
		req_t r;
		r.req_type   = code;
		r.write_addr = addr[11:0];
		r.write_data = data[7:0];
		r.count      = cnt[12:0];
		return r;
	endfunction

	function automatic plan_row_t free_row(req_t q);
		plan_row_t p;
		p.req   = q;
		p.typed = 1'b0;
		p.beat  = '0;
		return p;
	endfunction

	function automatic plan_row_t fixed_row(req_t q, logic [31:0] v, logic ir, int ni,
			logic nv);
		plan_row_t p;
		p.req             = q;
		p.typed           = 1'b1;
		p.beat.value      = v;
		p.beat.last       = 1'b1;
		p.beat.in_range   = ir;
		p.beat.next_index = ni[12:0];
		p.beat.next_valid = nv;
		return p;
	endfunction

	function automatic req_t random_request();
		int         sel;
		int         cnt;
		logic [2:0] code;
		sel = $urandom_range(0, 99);
		cnt = $urandom_range(0, 4096);
		if (sel < 14) begin
			code = REQ_WRITE;
		end else if (sel < 38) begin
			code = REQ_BITS;
			if ($urandom_range(0, 99) < 85)
				cnt = $urandom_range(0, 33);
		end else if (sel < 48) begin
			code = REQ_BYTE;
		end else if (sel < 58) begin
			code = REQ_WORD;
		end else if (sel < 68) begin
			code = REQ_SKIP;
			if ($urandom_range(0, 99) < 80)
				cnt = $urandom_range(0, 6);
		end else if (sel < 76) begin
			code = REQ_RESTART;
		end else if (sel < 96) begin
			code = REQ_COPY;
			cnt = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(0, 100);
		end else begin
			code = REQ_UNUSED;
		end
		return make_req(code, $urandom_range(0, 4095), $urandom_range(0, 255), cnt);
	endfunction

	task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatch_count++;
		if (mismatch_count <= REPORT_CAP)
			$display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
					want);
	endtask

	// offer one request beat, then update the mirror once it is taken
	task automatic issue(req_t q);
		while ($urandom_range(0, 99) < tx_idle_pct)
			@(negedge clk) in_valid <= 1'b0;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= q;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		predict_results(q);
	endtask

	task automatic pause_until_drained();
		@(negedge clk) in_valid <= 1'b0;
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic drain_and_wait();
		pause_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic write_size(int v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v[12:0];
		@(negedge clk) cfg_wr_en <= 1'b0;
		size_m = v;
	endtask

	always @(negedge clk) begin
		if (arst_n && hold_off_pending) begin
			hold_off_pending = 1'b0;
			out_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
		end
		out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_beats.size() == 0) begin
				note_mismatch("beat with nothing pending", out_data.value, '0);
			end else begin
				want_beat = expected_beats.pop_front();
				if (out_data.value !== want_beat.value)
					note_mismatch("value", out_data.value, want_beat.value);
				if (out_data.last !== want_beat.last)
					note_mismatch("last", out_data.last, want_beat.last);
				if (out_data.in_range !== want_beat.in_range)
					note_mismatch("in_range", out_data.in_range, want_beat.in_range);
				if (out_data.next_index !== want_beat.next_index)
					note_mismatch("next_index", out_data.next_index, want_beat.next_index);
				if (out_data.next_valid !== want_beat.next_valid)
					note_mismatch("next_valid", out_data.next_valid, want_beat.next_valid);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("msb_first_bit_reader_core test failed");
			$finish;
		end
	end

	initial begin : stimulus
		plan_row_t plan [$];
		int        sizes [PHASE_COUNT];
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int a = 0; a < BUFFER_BYTES; a++)
			issue(make_req(REQ_WRITE, a, $urandom_range(0, 255), $urandom_range(0, 4096)));

		plan.push_back(free_row(make_req(REQ_WRITE, 0, 8'hA5, 0)));
		plan.push_back(free_row(make_req(REQ_WRITE, 1, 8'hFF, 0)));
		plan.push_back(free_row(make_req(REQ_WRITE, 2, 8'h00, 0)));
		plan.push_back(free_row(make_req(REQ_WRITE, 4095, 8'h81, 0)));
		plan.push_back(fixed_row(make_req(REQ_RESTART, 0, 0, 0), 32'h0, 1'b1, 0, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BITS, 0, 0, 0), 32'h0, 1'b1, 0, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BITS, 0, 0, 1), 32'h1, 1'b1, 1, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BITS, 0, 0, 4), 32'h4, 1'b1, 1, 1'b1));
		plan.push_back(free_row(make_req(REQ_BITS, 0, 0, 4096)));
		plan.push_back(fixed_row(make_req(REQ_RESTART, 0, 0, 0), 32'h0, 1'b1, 0, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BYTE, 0, 0, 0), 32'hA5, 1'b1, 1, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_WORD, 0, 0, 0), 32'hFF00, 1'b1, 3, 1'b1));
		plan.push_back(free_row(make_req(REQ_BITS, 0, 0, 5)));
		plan.push_back(free_row(make_req(REQ_COPY, 0, 0, 3)));
		plan.push_back(fixed_row(make_req(REQ_SKIP, 0, 0, 4096), 32'h0, 1'b0, 4096, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BYTE, 0, 0, 0), 32'h0, 1'b0, 4096, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BITS, 0, 0, 3), 32'h0, 1'b0, 4096, 1'b0));
		plan.push_back(free_row(make_req(REQ_COPY, 0, 0, 0)));
		plan.push_back(fixed_row(make_req(REQ_WORD, 0, 0, 0), 32'h0, 1'b0, 4096, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_RESTART, 0, 0, 0), 32'h0, 1'b1, 0, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_SKIP, 0, 0, 4095), 32'h0, 1'b1, 4095, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_BYTE, 0, 0, 0), 32'h81, 1'b0, 4096, 1'b1));
		plan.push_back(fixed_row(make_req(REQ_RESTART, 0, 0, 0), 32'h0, 1'b1, 0, 1'b1));
		plan.push_back(free_row(make_req(REQ_COPY, 0, 0, 100)));
		plan.push_back(free_row(make_req(REQ_SKIP, 0, 0, 0)));
		plan.push_back(free_row(make_req(REQ_UNUSED, 4095, 8'hFF, 8191)));
		plan.push_back(free_row(make_req(REQ_SKIP, 0, 0, 4030)));
		plan.push_back(free_row(make_req(REQ_COPY, 0, 0, 64)));

		tx_idle_pct = 36;
		rx_idle_pct = 55;
		foreach (plan[i]) begin
			issue(plan[i].req);
			if (plan[i].typed) begin
				void'(expected_beats.pop_back());
				expected_beats.push_back(plan[i].beat);
			end
		end

		sizes = '{300, 1, BUFFER_BYTES, 0, 16, BUFFER_BYTES};
		sizes[3] = $urandom_range(2, BUFFER_BYTES - 1);
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			drain_and_wait();
			write_size(sizes[ph]);
			case (ph / 2)
				0: begin
					tx_idle_pct = 36;
					rx_idle_pct = 55;
				end
				1: begin
					tx_idle_pct = 55;
					rx_idle_pct = 36;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				issue(random_request());
				if (ph == PHASE_COUNT - 1 && k == 20)
					hold_off_pending = 1'b1;
				if (ph == PHASE_COUNT - 1 && k == 40)
					pause_until_drained();
			end
		end

		drain_and_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("msb_first_bit_reader_core test passed");
		else
			$display("msb_first_bit_reader_core test failed");
		$finish;
	end

endmodule

### sim.f
sv/msbr_pkg.sv
sv/msb_first_bit_reader_core.sv
test/msb_first_bit_reader_core_tb.sv
